[src/text_glyph_layout_top_macros.svh]
// Assertion shorthands for the text glyph layout block.
`ifndef TEXT_GLYPH_LAYOUT_TOP_MACROS_SVH
`define TEXT_GLYPH_LAYOUT_TOP_MACROS_SVH

// Check while out of reset.
`define TGL_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define TGL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tgl_pkg.sv]
package tgl_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_OPEN_BR   = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BR  = 8'h5D;
    localparam logic [7:0] CH_CIRCLE    = 8'h43;
    localparam logic [7:0] CH_SQUARE    = 8'h53;
    localparam logic [7:0] CH_CROSS     = 8'h58;
    localparam logic [7:0] CH_TRIANGLE  = 8'h54;
    localparam logic [7:0] ASCII_OFFSET = 8'h20;
    localparam logic [7:0] KANA_OFFSET  = 8'h40;
    localparam logic [4:0] KANA_ADVANCE = 5'd7;
    localparam logic [4:0] TILE_ADVANCE = 5'd16;
    localparam logic [15:0] LINE_STEP   = 16'd20;

    localparam logic [1:0] TILE_CIRCLE   = 2'd0;
    localparam logic [1:0] TILE_SQUARE   = 2'd1;
    localparam logic [1:0] TILE_CROSS    = 2'd2;
    localparam logic [1:0] TILE_TRIANGLE = 2'd3;

    localparam logic [4:0] WIDTH_ROM [96] = '{
        5'd7, 5'd5, 5'd5, 5'd8, 5'd7, 5'd8, 5'd7, 5'd5,
        5'd6, 5'd5, 5'd8, 5'd7, 5'd6, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd6, 5'd8, 5'd8, 5'd8, 5'd8, 5'd7, 5'd7,
        5'd8, 5'd8, 5'd4, 5'd4, 5'd6, 5'd8, 5'd6, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd3, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd6, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd6, 5'd7, 5'd5, 5'd7, 5'd5, 5'd6, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd3, 5'd8, 5'd8, 5'd4, 5'd8, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd3, 5'd7, 5'd7, 5'd0
    };

    typedef enum logic [1:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_GLYPH,
        OP_TILE
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [1:0] tile_code;
        logic [6:0] src_x;
        logic [7:0] src_y;
        logic [4:0] advance;
        logic       last;
    } t_op;

    typedef struct packed {
        logic        first;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [1:0]  count;
        t_op [2:0]   ops;
    } t_entry;

    typedef struct packed {
        logic        is_tile;
        logic [1:0]  tile_code;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [6:0]  src_x;
        logic [7:0]  src_y;
        logic [4:0]  advance;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } t_tile_hit;

    function automatic t_op classify_byte(logic [7:0] c);
        t_op        op;
        logic [7:0] cell_idx;
        op       = '0;
        cell_idx = '0;
        if (c == CH_NEWLINE) begin
            op.kind = OP_NEWLINE;
        end else if (c >= 8'h20 && c < 8'h80) begin
            cell_idx   = c - ASCII_OFFSET;
            op.kind    = OP_GLYPH;
            op.advance = WIDTH_ROM[cell_idx[6:0]];
        end else if (c >= 8'hA0 && c < 8'hE0) begin
            cell_idx   = c - KANA_OFFSET;
            op.kind    = OP_GLYPH;
            op.advance = KANA_ADVANCE;
        end
        if (op.kind == OP_GLYPH) begin
            op.src_x = {cell_idx[3:0], 3'b000};
            op.src_y = {cell_idx[7:4], 4'b0000};
        end
        return op;
    endfunction

    function automatic t_tile_hit tile_lookup(logic [7:0] c);
        t_tile_hit t;
        t = '0;
        case (c)
            CH_CIRCLE:   t = '{hit: 1'b1, code: TILE_CIRCLE};
            CH_SQUARE:   t = '{hit: 1'b1, code: TILE_SQUARE};
            CH_CROSS:    t = '{hit: 1'b1, code: TILE_CROSS};
            CH_TRIANGLE: t = '{hit: 1'b1, code: TILE_TRIANGLE};
            default:     t = '0;
        endcase
        return t;
    endfunction

endpackage

[src/tgl_front.sv]
module tgl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_text_byte,
    input  logic            i_first,
    input  logic            i_last,
    input  logic [15:0]     i_start_x,
    input  logic [15:0]     i_start_y,
    input  logic            i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output tgl_pkg::t_entry o_entry
);
    import tgl_pkg::*;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_OPEN = 2'd1;
    localparam logic [1:0] HELD_PAIR = 2'd2;

    logic [1:0] r_held_cnt, n_held_cnt;
    logic [7:0] r_held_byte, n_held_byte;
    logic [1:0] held;
    logic [1:0] n_ops;
    t_op [2:0]  ops;
    t_tile_hit  tile;
    logic       seen;
    logic       emits;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        held        = i_first ? HELD_NONE : r_held_cnt;
        n_held_cnt  = HELD_NONE;
        n_held_byte = r_held_byte;
        ops         = '0;
        n_ops       = 2'd0;
        tile        = tile_lookup(r_held_byte);
        case (held)
            HELD_OPEN: begin
                if (i_last) begin
                    ops[0] = classify_byte(CH_OPEN_BR);
                    ops[1] = classify_byte(i_text_byte);
                    n_ops  = 2'd2;
                end else begin
                    n_held_byte = i_text_byte;
                    n_held_cnt  = HELD_PAIR;
                end
            end
            HELD_PAIR: begin
                if (i_text_byte == CH_CLOSE_BR && tile.hit) begin
                    ops[0].kind      = OP_TILE;
                    ops[0].tile_code = tile.code;
                    ops[0].advance   = TILE_ADVANCE;
                    n_ops            = 2'd1;
                end else begin
                    ops[0] = classify_byte(CH_OPEN_BR);
                    if (r_held_byte == CH_OPEN_BR && !i_last) begin
                        n_held_byte = i_text_byte;
                        n_held_cnt  = HELD_PAIR;
                        n_ops       = 2'd1;
                    end else begin
                        ops[1] = classify_byte(r_held_byte);
                        if (i_text_byte == CH_OPEN_BR && !i_last) begin
                            n_held_cnt = HELD_OPEN;
                            n_ops      = 2'd2;
                        end else begin
                            ops[2] = classify_byte(i_text_byte);
                            n_ops  = 2'd3;
                        end
                    end
                end
            end
            default: begin
                if (i_text_byte == CH_OPEN_BR && !i_last) begin
                    n_held_cnt = HELD_OPEN;
                end else begin
                    ops[0] = classify_byte(i_text_byte);
                    n_ops  = 2'd1;
                end
            end
        endcase
        seen = 1'b0;
        for (int i = 2; i >= 0; i--) begin
            emits       = (ops[i].kind == OP_GLYPH) || (ops[i].kind == OP_TILE);
            ops[i].last = emits && !seen;
            seen        = seen || emits;
        end
        o_entry.first   = i_first;
        o_entry.start_x = i_start_x;
        o_entry.start_y = i_start_y;
        o_entry.count   = (n_ops == 2'd0) ? 2'd1 : n_ops;
        o_entry.ops     = ops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= HELD_NONE;
        end else if (o_push) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_held_byte <= n_held_byte;
        end
    end

endmodule

[src/tgl_queue.sv]
module tgl_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tgl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tgl_pkg::t_entry o_head
);
    import tgl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/tgl_back.sv]
module tgl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tgl_pkg::t_entry  i_head,
    input  logic             i_m_ready,
    output logic             o_pop,
    output logic             o_m_valid,
    output tgl_pkg::t_result o_m_result
);
    import tgl_pkg::*;

    logic [1:0]  r_idx;
    logic [15:0] r_cur_x, r_cur_y, r_origin;
    logic [15:0] n_cur_x, n_cur_y;
    logic        r_out_valid;
    t_result     r_out;
    t_op         op;
    logic        load;
    logic [15:0] base_x, base_y, origin;
    logic        emits, out_free, fire, last_op;

    assign op       = i_head.ops[r_idx];
    assign load     = i_head.first && (r_idx == 2'd0);
    assign base_x   = load ? i_head.start_x : r_cur_x;
    assign base_y   = load ? i_head.start_y : r_cur_y;
    assign origin   = load ? i_head.start_x : r_origin;
    assign emits    = (op.kind == OP_GLYPH) || (op.kind == OP_TILE);
    assign out_free = !r_out_valid || i_m_ready;
    assign fire     = i_q_valid && (!emits || out_free);
    assign last_op  = (r_idx == (i_head.count - 2'd1));
    assign o_pop    = fire && last_op;

    assign o_m_valid  = r_out_valid;
    assign o_m_result = r_out;

    always_comb begin
        n_cur_x = base_x;
        n_cur_y = base_y;
        case (op.kind)
            OP_NEWLINE: begin
                n_cur_x = origin;
                n_cur_y = base_y + LINE_STEP;
            end
            OP_GLYPH, OP_TILE: begin
                n_cur_x = base_x + {11'b0, op.advance};
            end
            default: begin
                n_cur_x = base_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_origin    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_idx   <= last_op ? 2'd0 : r_idx + 2'd1;
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_origin <= origin;
            end
            if (fire && emits) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emits) begin
            r_out.is_tile     <= (op.kind == OP_TILE);
            r_out.tile_code   <= op.tile_code;
            r_out.dest_x      <= base_x;
            r_out.dest_y      <= base_y;
            r_out.src_x       <= op.src_x;
            r_out.src_y       <= op.src_y;
            r_out.advance     <= op.advance;
            r_out.last_of_run <= op.last;
        end
    end

endmodule

[src/text_glyph_layout_top.sv]
// Text glyph layout: takes one string byte per transaction and returns font glyph and
// button tile placements. The front end classifies each byte and resolves the
// '[' code ']' lookahead, and writes up to three placement steps into a queue of
// QUEUE_DEPTH entries; the placement engine walks the cursor one step per cycle while
// the output is not stalled. Plain text, where a byte gives at most one step (glyph,
// tile, newline or nothing), streams at one byte per cycle while the output is ready;
// a byte that flushes held lookahead takes two or three steps of the placement engine,
// and the queue hides short bursts of these. The first placement of a byte passes
// through the queue and the output register before it is valid; tlast marks the last
// placement caused by one byte.
module text_glyph_layout_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // text_byte, start_x, start_y
    input  logic        i_s_tlast,  // last_byte
    input  logic        i_s_tuser,  // first_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // tile_code, dest_x, dest_y, src_x, src_y, advance
    output logic        o_m_tlast,  // last_of_run
    output logic        o_m_tuser   // is_tile
);
    import tgl_pkg::*;

    logic    q_full, q_push, q_valid, q_pop;
    t_entry  push_entry, head_entry;
    t_result result;

    tgl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_text_byte (i_s_tdata[7:0]),
        .i_first     (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_start_x   (i_s_tdata[23:8]),
        .i_start_y   (i_s_tdata[39:24]),
        .i_q_full    (q_full),
        .o_ready     (o_s_tready),
        .o_push      (q_push),
        .o_entry     (push_entry)
    );

    tgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_entry)
    );

    tgl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_head     (head_entry),
        .i_m_ready  (i_m_tready),
        .o_pop      (q_pop),
        .o_m_valid  (o_m_tvalid),
        .o_m_result (result)
    );

    assign o_m_tdata = {2'b00, result.advance, result.src_y, result.src_x,
                        result.dest_y, result.dest_x, result.tile_code};
    assign o_m_tlast = result.last_of_run;
    assign o_m_tuser = result.is_tile;

endmodule

[src/tgl_checker.sv]
`include "text_glyph_layout_top_macros.svh"

module tgl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    `TGL_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
    `TGL_ASSERT_ON(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "stalled result changed")
    `TGL_ASSERT_ON(a_tile_shape, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tdata[48:34] == 15'd0) && (o_m_tdata[53:49] == 5'd16), "tile with glyph source or wrong advance")
    `TGL_ASSERT_ON(a_glyph_shape, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> (o_m_tdata[1:0] == 2'd0) && (o_m_tdata[53:49] <= 5'd8), "glyph with tile code or wide advance")

endmodule

bind text_glyph_layout_top tgl_checker u_checker (.*);
